FILE: rtl/rsfd_pkg.sv
// shared types and constants for the raw sample frame decoder
package rsfd_pkg;

    // default clamp for the channel count register
    localparam int unsigned DefMaxChannels = 256;

    // configuration port widths
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;

    // depth of the queue between front and back
    localparam int unsigned FifoDepth = 4;

    // sample encodings
    typedef enum logic [2:0] {
        FMT_U8  = 3'd0,
        FMT_S8  = 3'd1,
        FMT_U16 = 3'd2,
        FMT_S16 = 3'd3,
        FMT_U32 = 3'd4,
        FMT_S32 = 3'd5,
        FMT_F32 = 3'd6,
        FMT_F64 = 3'd7
    } t_fmt;

    // configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_START_SKIP    = 3'd0,
        REG_HEADER_SKIP   = 3'd1,
        REG_FOOTER_SKIP   = 3'd2,
        REG_CHANNEL_COUNT = 3'd3,
        REG_SAMPLE_FORMAT = 3'd4,
        REG_BIG_ENDIAN    = 3'd5
    } t_reg_index;

    // reset values of the configuration registers
    localparam logic [31:0] RstStartSkip    = 32'd0;
    localparam logic [15:0] RstHeaderSkip   = 16'd0;
    localparam logic [15:0] RstFooterSkip   = 16'd20;
    localparam logic [8:0]  RstChannelCount = 9'd16;
    localparam t_fmt        RstSampleFormat = FMT_S32;
    localparam logic        RstBigEndian    = 1'b0;

    // live configuration
    typedef struct packed {
        logic [31:0] start_skip;
        logic [15:0] header_skip;
        logic [15:0] footer_skip;
        logic [8:0]  channel_count;
        t_fmt        fmt;
        logic        big_endian;
    } t_cfg;

    // assembled sample handed from front to back
    typedef struct packed {
        logic [63:0] assembly;
        t_fmt        fmt;
        logic [7:0]  channel;
        logic        last;
    } t_sample_word;

    // conversion pipeline stage between classify and round
    typedef struct packed {
        logic        direct;
        logic [31:0] direct_bits;
        logic        sign;
        logic [7:0]  exp_base;
        logic [63:0] value;
        logic [5:0]  rsh;
        logic [4:0]  lsh;
        logic [7:0]  channel;
        logic        last;
    } t_conv_stage;

endpackage

FILE: rtl/raw_sample_frame_decoder.sv
// raw sample frame decoder top level: configuration registers and channel wiring
// Usage:
// Input channel carries one raw stream byte per word (i_in_valid, o_in_stall).
// The stream starts with start_skip bytes, then frames of header bytes,
// channel_count samples and footer bytes. Each finished sample leaves on the
// output channel (o_out_valid, i_out_stall) as float32 bits with its channel
// number and a last-of-frame flag; skipped bytes and partial samples give none.
// Throughput: one byte per cycle while the queue has room. The front walks
// regions and assembles bytes combinationally; samples pass a 4-word queue
// into a two stage converter (classify, then round and pack) ending in the output
// register. A sample passes the queue, the classify register and the output
// register before it is valid on the output.
// When the receiver stalls, the converter holds, the queue fills, and then
// o_in_stall rises; no word is lost or repeated.
// Reset (synchronous, active low) empties the queue and converter, returns to
// the start skip and restores all configuration registers to their defaults.
// Configuration is written through i_cfg_wr_en/i_cfg_index/i_cfg_wr_data while
// no sample is in flight; it takes effect on the next byte.
module raw_sample_frame_decoder #(
    parameter int unsigned MAX_CHANNELS = rsfd_pkg::DefMaxChannels
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rsfd_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [rsfd_pkg::CfgDataWidth-1:0]  i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_raw_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [31:0]                        o_sample_bits,
    output logic [7:0]                         o_channel_index,
    output logic                               o_frame_last
);

    rsfd_pkg::t_cfg         r_cfg;
    logic                   in_take;
    logic                   push;
    rsfd_pkg::t_sample_word push_word;
    logic                   fifo_full;
    logic                   fifo_valid;
    logic                   fifo_pop;
    rsfd_pkg::t_sample_word fifo_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_skip    <= rsfd_pkg::RstStartSkip;
            r_cfg.header_skip   <= rsfd_pkg::RstHeaderSkip;
            r_cfg.footer_skip   <= rsfd_pkg::RstFooterSkip;
            r_cfg.channel_count <= rsfd_pkg::RstChannelCount;
            r_cfg.fmt           <= rsfd_pkg::RstSampleFormat;
            r_cfg.big_endian    <= rsfd_pkg::RstBigEndian;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rsfd_pkg::REG_START_SKIP:    r_cfg.start_skip    <= i_cfg_wr_data;
                rsfd_pkg::REG_HEADER_SKIP:   r_cfg.header_skip   <= i_cfg_wr_data[15:0];
                rsfd_pkg::REG_FOOTER_SKIP:   r_cfg.footer_skip   <= i_cfg_wr_data[15:0];
                rsfd_pkg::REG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_wr_data[8:0];
                rsfd_pkg::REG_SAMPLE_FORMAT: begin
                    r_cfg.fmt <= rsfd_pkg::t_fmt'(i_cfg_wr_data[2:0]);
                end
                rsfd_pkg::REG_BIG_ENDIAN:    r_cfg.big_endian    <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // input word is taken whenever the queue has room
    assign o_in_stall = fifo_full;
    assign in_take    = i_in_valid && !fifo_full;

    rsfd_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (in_take),
        .i_byte  (i_raw_byte),
        .o_push  (push),
        .o_word  (push_word)
    );

    rsfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_word  (fifo_word)
    );

    rsfd_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (fifo_valid),
        .i_word          (fifo_word),
        .o_take          (fifo_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_sample_bits   (o_sample_bits),
        .o_channel_index (o_channel_index),
        .o_frame_last    (o_frame_last)
    );

endmodule

FILE: rtl/rsfd_front.sv
// front part: region tracking and sample byte assembly
module rsfd_front #(
    parameter int unsigned MAX_CHANNELS = rsfd_pkg::DefMaxChannels
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rsfd_pkg::t_cfg         i_cfg,
    input  logic                   i_take,
    input  logic [7:0]             i_byte,
    output logic                   o_push,
    output rsfd_pkg::t_sample_word o_word
);

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_HEADER  = 2'd1,
        PH_SAMPLES = 2'd2,
        PH_FOOTER  = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_start_cnt, n_start_cnt;
    logic [15:0] r_region_cnt, n_region_cnt;
    logic [7:0]  r_chan_cnt, n_chan_cnt;
    logic [2:0]  r_bis, n_bis;
    logic [63:0] r_asm, n_asm;

    logic        hdr_go;
    logic [15:0] hdr_cnt;
    logic        samp_go;
    logic [7:0]  ch;
    logic [2:0]  bis;
    logic [63:0] base;
    logic [63:0] asm_val;
    logic [3:0]  next_bis;
    logic [3:0]  size;
    logic [8:0]  eff_ch;
    logic        complete;
    logic        last;

    // bytes per sample
    always_comb begin
        unique case (i_cfg.fmt)
            rsfd_pkg::FMT_U8, rsfd_pkg::FMT_S8:   size = 4'd1;
            rsfd_pkg::FMT_U16, rsfd_pkg::FMT_S16: size = 4'd2;
            rsfd_pkg::FMT_F64:                    size = 4'd8;
            default:                              size = 4'd4;
        endcase
    end

    // channel count clamped to 1..MAX_CHANNELS
    always_comb begin
        if (i_cfg.channel_count == 9'd0) begin
            eff_ch = 9'd1;
        end else if (i_cfg.channel_count > 9'(MAX_CHANNELS)) begin
            eff_ch = 9'(MAX_CHANNELS);
        end else begin
            eff_ch = i_cfg.channel_count;
        end
    end

    // region walk: empty regions are passed within the same byte
    always_comb begin
        n_phase      = r_phase;
        n_start_cnt  = r_start_cnt;
        n_region_cnt = r_region_cnt;
        n_chan_cnt   = r_chan_cnt;
        n_bis        = r_bis;
        n_asm        = r_asm;
        hdr_go       = 1'b0;
        hdr_cnt      = r_region_cnt;
        samp_go      = 1'b0;
        ch           = r_chan_cnt;
        bis          = r_bis;
        base         = '0;
        asm_val      = '0;
        next_bis     = '0;
        complete     = 1'b0;
        last         = 1'b0;

        unique case (r_phase)
            PH_START: begin
                if (r_start_cnt < i_cfg.start_skip) begin
                    n_start_cnt = r_start_cnt + 32'd1;
                end else begin
                    hdr_go  = 1'b1;
                    hdr_cnt = '0;
                end
            end
            PH_FOOTER: begin
                if (r_region_cnt < i_cfg.footer_skip) begin
                    n_region_cnt = r_region_cnt + 16'd1;
                end else begin
                    hdr_go  = 1'b1;
                    hdr_cnt = '0;
                end
            end
            PH_HEADER: begin
                hdr_go = 1'b1;
            end
            PH_SAMPLES: begin
                samp_go = 1'b1;
            end
        endcase

        if (hdr_go) begin
            if (hdr_cnt < i_cfg.header_skip) begin
                n_phase      = PH_HEADER;
                n_region_cnt = hdr_cnt + 16'd1;
            end else begin
                samp_go = 1'b1;
                ch      = '0;
                bis     = '0;
            end
        end

        // byte assembly into the current sample
        if (samp_go) begin
            base = (bis == 3'd0) ? 64'd0 : r_asm;
            if (i_cfg.big_endian) begin
                asm_val = {base[55:0], i_byte};
            end else begin
                asm_val = base | (64'(i_byte) << {bis, 3'b000});
            end
            n_asm    = asm_val;
            next_bis = {1'b0, bis} + 4'd1;
            if (next_bis < size) begin
                n_phase    = PH_SAMPLES;
                n_bis      = next_bis[2:0];
                n_chan_cnt = ch;
            end else begin
                complete = 1'b1;
                n_bis    = '0;
                last     = (({1'b0, ch} + 9'd1) >= eff_ch);
                if (last) begin
                    n_phase      = PH_FOOTER;
                    n_region_cnt = '0;
                    n_chan_cnt   = '0;
                end else begin
                    n_phase    = PH_SAMPLES;
                    n_chan_cnt = ch + 8'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_start_cnt  <= '0;
            r_region_cnt <= '0;
            r_chan_cnt   <= '0;
            r_bis        <= '0;
            r_asm        <= '0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_start_cnt  <= n_start_cnt;
            r_region_cnt <= n_region_cnt;
            r_chan_cnt   <= n_chan_cnt;
            r_bis        <= n_bis;
            r_asm        <= n_asm;
        end
    end

    // completed sample toward the queue
    assign o_push          = i_take && complete;
    assign o_word.assembly = asm_val;
    assign o_word.fmt      = i_cfg.fmt;
    assign o_word.channel  = ch;
    assign o_word.last     = last;

endmodule

FILE: rtl/rsfd_fifo.sv
// short queue of assembled samples between front and back
module rsfd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rsfd_pkg::t_sample_word i_word,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output rsfd_pkg::t_sample_word o_word
);

    localparam int unsigned PtrWidth = $clog2(rsfd_pkg::FifoDepth);
    localparam int unsigned CntWidth = $clog2(rsfd_pkg::FifoDepth + 1);

    rsfd_pkg::t_sample_word r_mem [rsfd_pkg::FifoDepth];
    logic [PtrWidth-1:0]    r_wr_ptr;
    logic [PtrWidth-1:0]    r_rd_ptr;
    logic [CntWidth-1:0]    r_count;
    logic                   do_push;
    logic                   do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= PtrWidth'(32'(r_wr_ptr) + 1);
            end
            if (do_pop) begin
                r_rd_ptr <= PtrWidth'(32'(r_rd_ptr) + 1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntWidth'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntWidth'(1);
            end
        end
    end

    assign o_full  = (r_count == CntWidth'(rsfd_pkg::FifoDepth));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

FILE: rtl/rsfd_conv.sv
// back part: two stage conversion of a sample to float32 bits
module rsfd_conv (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rsfd_pkg::t_sample_word i_word,
    output logic                   o_take,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_sample_bits,
    output logic [7:0]             o_channel_index,
    output logic                   o_frame_last
);

    logic                  advance;
    logic                  r_s1_valid;
    rsfd_pkg::t_conv_stage r_s1, n_s1;
    logic                  r_out_valid;
    logic [31:0]           r_out_bits, n_out_bits;
    logic [7:0]            r_out_chan;
    logic                  r_out_last;

    // classify stage signals
    logic [63:0]        a;
    logic               neg;
    logic [32:0]        mag;
    logic [5:0]         p;
    logic               is_int;
    logic [10:0]        e;
    logic [51:0]        m;
    logic signed [12:0] te;

    // round stage signals
    logic [63:0] rshifted;
    logic [63:0] rem;
    logic [63:0] half;
    logic        round_up;
    logic [24:0] keep;
    logic [30:0] sum;

    // the whole back pipeline moves unless the output word is held
    assign advance = !r_out_valid || !i_stall;
    assign o_take  = advance && i_valid;

    // classify: magnitude and exponent, or a finished special value
    always_comb begin
        a      = i_word.assembly;
        neg    = 1'b0;
        mag    = '0;
        p      = '0;
        is_int = 1'b1;
        e      = a[62:52];
        m      = a[51:0];
        te     = $signed({2'b00, e}) - 13'sd896;
        n_s1   = '0;
        n_s1.channel = i_word.channel;
        n_s1.last    = i_word.last;

        case (i_word.fmt)
            rsfd_pkg::FMT_U8: begin
                mag = {25'd0, a[7:0]};
            end
            rsfd_pkg::FMT_S8: begin
                neg = a[7];
                mag = a[7] ? (33'h100 - {25'd0, a[7:0]}) : {25'd0, a[7:0]};
            end
            rsfd_pkg::FMT_U16: begin
                mag = {17'd0, a[15:0]};
            end
            rsfd_pkg::FMT_S16: begin
                neg = a[15];
                mag = a[15] ? (33'h1_0000 - {17'd0, a[15:0]}) : {17'd0, a[15:0]};
            end
            rsfd_pkg::FMT_U32: begin
                mag = {1'b0, a[31:0]};
            end
            rsfd_pkg::FMT_S32: begin
                neg = a[31];
                mag = a[31] ? (33'h1_0000_0000 - {1'b0, a[31:0]}) : {1'b0, a[31:0]};
            end
            rsfd_pkg::FMT_F32: begin
                is_int           = 1'b0;
                n_s1.direct      = 1'b1;
                n_s1.direct_bits = a[31:0];
            end
            default: begin
                is_int = 1'b0;
                n_s1.sign = a[63];
                if (e == 11'h7FF) begin
                    n_s1.direct = 1'b1;
                    if (m == '0) begin
                        n_s1.direct_bits = {a[63], 8'hFF, 23'd0};
                    end else begin
                        n_s1.direct_bits = {a[63], 8'hFF, 1'b1, m[50:29]};
                    end
                end else if (e == 11'd0) begin
                    n_s1.direct      = 1'b1;
                    n_s1.direct_bits = {a[63], 31'd0};
                end else if (te >= 13'sd255) begin
                    n_s1.direct      = 1'b1;
                    n_s1.direct_bits = {a[63], 8'hFF, 23'd0};
                end else if (te >= 13'sd1) begin
                    n_s1.exp_base = 8'(te - 13'sd1);
                    n_s1.value    = {11'd0, 1'b1, m};
                    n_s1.rsh      = 6'd29;
                end else if (te <= -13'sd33) begin
                    n_s1.direct      = 1'b1;
                    n_s1.direct_bits = {a[63], 31'd0};
                end else begin
                    // result lands in the subnormal range
                    n_s1.exp_base = 8'd0;
                    n_s1.value    = {11'd0, 1'b1, m};
                    n_s1.rsh      = 6'(13'sd30 - te);
                end
            end
        endcase

        // integer: find the leading one
        for (int i = 0; i < 33; i++) begin
            if (mag[i]) begin
                p = 6'(i);
            end
        end

        if (is_int) begin
            n_s1.sign = neg;
            if (mag == '0) begin
                n_s1.direct      = 1'b1;
                n_s1.direct_bits = 32'd0;
            end else begin
                n_s1.exp_base = 8'(p) + 8'd126;
                n_s1.value    = {31'd0, mag};
                if (p <= 6'd23) begin
                    n_s1.lsh = 5'(6'd23 - p);
                end else begin
                    n_s1.rsh = p - 6'd23;
                end
            end
        end
    end

    // round to nearest even and pack; a mantissa carry bumps the exponent
    always_comb begin
        rshifted = r_s1.value >> r_s1.rsh;
        rem      = r_s1.value & ((64'd1 << r_s1.rsh) - 64'd1);
        half     = (r_s1.rsh == 6'd0) ? 64'd0 : (64'd1 << (r_s1.rsh - 6'd1));
        round_up = (r_s1.rsh != 6'd0) &&
                   ((rem > half) || ((rem == half) && rshifted[0]));
        if (r_s1.rsh != 6'd0) begin
            keep = rshifted[24:0] + {24'd0, round_up};
        end else begin
            keep = 25'(r_s1.value << r_s1.lsh);
        end
        sum = {r_s1.exp_base, 23'd0} + {6'd0, keep};
        if (r_s1.direct) begin
            n_out_bits = r_s1.direct_bits;
        end else if (sum[30:23] == 8'hFF) begin
            n_out_bits = {r_s1.sign, 8'hFF, 23'd0};
        end else begin
            n_out_bits = {r_s1.sign, sum};
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1       <= n_s1;
            r_out_bits <= n_out_bits;
            r_out_chan <= r_s1.channel;
            r_out_last <= r_s1.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_bits   = r_out_bits;
    assign o_channel_index = r_out_chan;
    assign o_frame_last    = r_out_last;

endmodule
